// ----- sv/mvt_pkg.sv -----
`default_nettype none

package mvt_pkg;

  // Table sizing
  localparam int TABLE_DEPTH = 16;
  localparam int MAX_PER_KEY = 2;
  localparam int AW          = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int KIND_W   = 2;
  localparam int DATA_W   = 32;
  localparam int CAP_W    = 5;
  localparam int STATUS_W = 2;
  localparam int FOUND_W  = 2;
  localparam int ENTRY_W  = 5;
  localparam int CFG_IDX_W = 1;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 80;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [AW-1:0]    addr_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAP    = 1'd0,
    CFG_ABSENT = 1'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPEND,
    S_MOVE_RD,
    S_MOVE_WR,
    S_DONE
  } state_e;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  // RAM access request from the sequencer
  typedef struct packed {
    logic   we;
    addr_t  waddr;
    entry_t wdata;
    logic   re;
    addr_t  raddr;
  } mem_req_t;

  // One result item
  typedef struct packed {
    logic               is_empty;
    logic               is_full;
    logic [ENTRY_W-1:0] entry_count;
    logic [FOUND_W-1:0] found_count;
    logic [DATA_W-1:0]  second_value;
    logic [DATA_W-1:0]  first_value;
    status_e            status;
  } res_t;

  // Capacity register saturated to 1..TABLE_DEPTH
  function automatic cnt_t eff_limit(input logic [CAP_W-1:0] cap);
    cnt_t lim;
    if (cap == '0) begin
      lim = CNT_W'(1);
    end else if (32'(cap) > TABLE_DEPTH) begin
      lim = CNT_W'(TABLE_DEPTH);
    end else begin
      lim = CNT_W'(cap);
    end
    return lim;
  endfunction

endpackage

`default_nettype wire

// ----- sv/two_value_multimap_table.sv -----
// A request is taken in the idle state; where a scan is needed it reads one stored entry a cycle
//   from the single RAM read port, followed where needed by the append write or the
//   move read and write, and the done state then loads the output register. in_tready is
//   high only in the idle state, so one request is in flight at a time. A waiting result
//   holds the sequencer in its done state, so a second request stalls behind it.
// Reset: rst_n synchronous, active low; clears the entry count, sets capacity to 16 and
//   the absent value to 0. The RAM is not cleared; only stored entries are ever read.
`default_nettype none

module two_value_multimap_table (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // config port
  input  wire logic                              cfg_we,
  input  wire logic [mvt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mvt_pkg::DATA_W-1:0]        cfg_data,
  // request stream
  input  wire logic                              in_tvalid,
  output      logic                              in_tready,
  input  wire logic [mvt_pkg::IN_TDATA_W-1:0]    in_tdata,  // key[31:0], value[63:32]
  input  wire logic [mvt_pkg::KIND_W-1:0]        in_tuser,  // kind[1:0]
  // result stream
  output      logic                              out_tvalid,
  input  wire logic                              out_tready,
  // status[1:0], first_value[33:2], second_value[65:34], found_count[67:66],
  // entry_count[72:68], is_full[73], is_empty[74], zero[79:75]
  output      logic [mvt_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  import mvt_pkg::*;

  mem_req_t mem_req;
  entry_t   mem_rdata;
  logic     res_valid;
  logic     res_free;
  res_t     res;
  logic     out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  assign res_free = !out_tvalid_r || out_tready;

  mvt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_kind  (in_tuser),
    .req_key   (in_tdata[DATA_W-1:0]),
    .req_value (in_tdata[2*DATA_W-1:DATA_W]),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_free  (res_free),
    .res       (res)
  );

  mvt_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ENTRY_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // Output register: holds one result until the transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_free) begin
      out_tvalid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && res_valid) begin
      out_tdata_r <= OUT_TDATA_W'(res);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

// ----- sv/mvt_ram.sv -----
`default_nettype none

module mvt_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/mvt_ctrl.sv -----
`default_nettype none

module mvt_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // config
  input  wire logic                           cfg_we,
  input  wire logic [mvt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mvt_pkg::DATA_W-1:0]     cfg_data,
  // request
  input  wire logic                           req_valid,
  output      logic                           req_ready,
  input  wire logic [mvt_pkg::KIND_W-1:0]     req_kind,
  input  wire logic [mvt_pkg::DATA_W-1:0]     req_key,
  input  wire logic [mvt_pkg::DATA_W-1:0]     req_value,
  // RAM
  output      mvt_pkg::mem_req_t              mem_req,
  input  wire mvt_pkg::entry_t                mem_rdata,
  // result
  output      logic                           res_valid,
  input  wire logic                           res_free,
  output      mvt_pkg::res_t                  res
);

  import mvt_pkg::*;

  state_e             state_r, state_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [DATA_W-1:0]  key_r, key_nxt;
  logic [DATA_W-1:0]  val_r, val_nxt;
  cnt_t               cnt_r, cnt_nxt;
  cnt_t               iss_r, iss_nxt;
  logic               rvld_r, rvld_nxt;
  cnt_t               ridx_r, ridx_nxt;
  logic [FOUND_W-1:0] hits_r, hits_nxt;
  logic [DATA_W-1:0]  first_r, first_nxt;
  logic [DATA_W-1:0]  second_r, second_nxt;
  status_e            status_r, status_nxt;
  addr_t              pos_r, pos_nxt;
  logic [CAP_W-1:0]   cap_r;
  logic [DATA_W-1:0]  absent_r;

  cnt_t lim;
  cnt_t last_idx;
  logic issue;
  logic last;
  logic key_hit;
  logic pair_hit;

  assign lim      = eff_limit(cap_r);
  assign last_idx = cnt_r - CNT_W'(1);
  assign last     = (ridx_r == last_idx);
  assign key_hit  = (mem_rdata.key == key_r);
  assign pair_hit = key_hit && (mem_rdata.value == val_r);

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= CAP_W'(16);
      absent_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_CAP) begin
        cap_r <= cfg_data[CAP_W-1:0];
      end
      if (cfg_index == CFG_ABSENT) begin
        absent_r <= cfg_data;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      rvld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rvld_r  <= rvld_nxt;
    end
  end

  // Request payload and scan bookkeeping
  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    key_r    <= key_nxt;
    val_r    <= val_nxt;
    iss_r    <= iss_nxt;
    ridx_r   <= ridx_nxt;
    hits_r   <= hits_nxt;
    first_r  <= first_nxt;
    second_r <= second_nxt;
    status_r <= status_nxt;
    pos_r    <= pos_nxt;
  end

  // Sequencer: scan entries one read per cycle, then append or move-last-into-hole as needed
  always_comb begin
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    key_nxt    = key_r;
    val_nxt    = val_r;
    cnt_nxt    = cnt_r;
    iss_nxt    = iss_r;
    rvld_nxt   = 1'b0;
    ridx_nxt   = ridx_r;
    hits_nxt   = hits_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    status_nxt = status_r;
    pos_nxt    = pos_r;
    issue      = 1'b0;

    mem_req.we    = 1'b0;
    mem_req.waddr = cnt_r[AW-1:0];
    mem_req.wdata = '{key: key_r, value: val_r};
    mem_req.re    = 1'b0;
    mem_req.raddr = iss_r[AW-1:0];

    req_ready = (state_r == S_IDLE);
    res_valid = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          kind_nxt   = req_kind;
          key_nxt    = req_key;
          val_nxt    = req_value;
          hits_nxt   = '0;
          first_nxt  = absent_r;
          second_nxt = absent_r;
          iss_nxt    = '0;
          status_nxt = ST_MISS;
          case (req_kind)
            KIND_ADD: begin
              if (cnt_r >= lim) begin
                status_nxt = ST_FULL;
                state_nxt  = S_DONE;
              end else if (cnt_r == '0) begin
                state_nxt = S_APPEND;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            KIND_SEARCH, KIND_REMOVE: begin
              state_nxt = (cnt_r == '0) ? S_DONE : S_SCAN;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        issue      = (iss_r < cnt_r);
        mem_req.re = issue;
        iss_nxt    = iss_r + CNT_W'(issue);
        rvld_nxt   = issue;
        ridx_nxt   = iss_r;
        if (rvld_r) begin
          case (kind_r)
            KIND_ADD: begin
              if (key_hit && hits_r == 2'd1) begin
                status_nxt = ST_MISS;
                state_nxt  = S_DONE;
              end else begin
                if (key_hit) begin
                  hits_nxt = hits_r + 2'd1;
                end
                if (last) begin
                  state_nxt = S_APPEND;
                end
              end
            end
            KIND_SEARCH: begin
              if (key_hit) begin
                if (hits_r == '0) begin
                  first_nxt = mem_rdata.value;
                end else begin
                  second_nxt = mem_rdata.value;
                end
                hits_nxt = hits_r + 2'd1;
              end
              if ((key_hit && hits_r == 2'd1) || last) begin
                status_nxt = (key_hit || hits_r != '0) ? ST_OK : ST_MISS;
                state_nxt  = S_DONE;
              end
            end
            KIND_REMOVE: begin
              if (pair_hit) begin
                pos_nxt = ridx_r[AW-1:0];
                if (last) begin
                  cnt_nxt    = last_idx;
                  status_nxt = ST_OK;
                  state_nxt  = S_DONE;
                end else begin
                  state_nxt = S_MOVE_RD;
                end
              end else if (last) begin
                status_nxt = ST_MISS;
                state_nxt  = S_DONE;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_APPEND: begin
        mem_req.we = 1'b1;
        cnt_nxt    = cnt_r + CNT_W'(1);
        status_nxt = ST_OK;
        state_nxt  = S_DONE;
      end

      S_MOVE_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = last_idx[AW-1:0];
        state_nxt     = S_MOVE_WR;
      end

      S_MOVE_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos_r;
        mem_req.wdata = mem_rdata;
        cnt_nxt       = last_idx;
        status_nxt    = ST_OK;
        state_nxt     = S_DONE;
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result fields; count and flags reflect the table after this request
  always_comb begin
    res.status       = status_r;
    res.first_value  = first_r;
    res.second_value = second_r;
    res.found_count  = (kind_r == KIND_SEARCH) ? hits_r : '0;
    res.entry_count  = ENTRY_W'(cnt_r);
    res.is_full      = (cnt_r >= lim);
    res.is_empty     = (cnt_r == '0);
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= TABLE_DEPTH)
    else $error("entry count beyond table depth");

  a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (state_r == S_APPEND || state_r == S_MOVE_WR))
    else $error("RAM write outside append or move");

  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_APPEND |-> cnt_r < lim)
    else $error("append at or above limit");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && cnt_r != $past(cnt_r)) |->
      (cnt_r == $past(cnt_r) + CNT_W'(1) || cnt_r == $past(cnt_r) - CNT_W'(1)))
    else $error("entry count moved by more than one");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && rvld_r) |-> ridx_r < cnt_r)
    else $error("scan read beyond stored entries");
`endif

endmodule

`default_nettype wire

// ----- verif/two_value_multimap_table_tb.sv -----
`timescale 1ns / 1ps

module two_value_multimap_table_tb;
  import mvt_pkg::*;

  localparam int IDLE_LIMIT   = 3000;  // cycles with no transfer at all
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 180;
  localparam int STALL_AT     = 650;   // reply count that starts the long hold-off
  localparam int STALL_CYCLES = 300;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;  // kind code with no request behind it

  // Table predictor and queue of awaited replies
  class multimap_checker;
    logic [DATA_W-1:0] keys [TABLE_DEPTH];
    logic [DATA_W-1:0] vals [TABLE_DEPTH];
    int unsigned       count;
    logic [CAP_W-1:0]  capacity;
    logic [DATA_W-1:0] absent;
    res_t              awaited_replies [$];
    int                errors;

    function new();
      count    = 0;
      capacity = CAP_W'(16);
      absent   = '0;
      errors   = 0;
    endfunction

    function void set_register(cfg_idx_e idx, logic [DATA_W-1:0] data);
      if (idx == CFG_CAP) begin
        capacity = data[CAP_W-1:0];
      end else begin
        absent = data;
      end
    endfunction

    function int pending();
      return awaited_replies.size();
    endfunction

    // Apply one accepted request to the table and queue its reply
    function void note_request(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] key,
                               logic [DATA_W-1:0] val);
      res_t        r;
      int unsigned lim;
      int unsigned hits;
      int unsigned found;
      int unsigned last;
      bit          done;
      lim = (capacity == 0) ? 1 : (capacity > TABLE_DEPTH) ? TABLE_DEPTH : capacity;
      r = '0;
      r.status       = ST_MISS;
      r.first_value  = absent;
      r.second_value = absent;
      found = 0;
      case (kind)
        KIND_ADD: begin
          if (count >= lim) begin
            r.status = ST_FULL;
          end else begin
            hits = 0;
            for (int i = 0; i < count; i++) begin
              if (keys[i] == key) hits++;
            end
            if (hits < MAX_PER_KEY) begin
              keys[count] = key;
              vals[count] = val;
              count++;
              r.status = ST_OK;
            end
          end
        end
        KIND_SEARCH: begin
          for (int i = 0; i < count && found < MAX_PER_KEY; i++) begin
            if (keys[i] == key) begin
              if (found == 0) r.first_value = vals[i];
              else r.second_value = vals[i];
              found++;
            end
          end
          if (found != 0) r.status = ST_OK;
        end
        KIND_REMOVE: begin
          done = 0;
          for (int i = 0; i < count && !done; i++) begin
            if (keys[i] == key && vals[i] == val) begin
              // last entry fills the hole
              last    = count - 1;
              keys[i] = keys[last];
              vals[i] = vals[last];
              count   = last;
              r.status = ST_OK;
              done    = 1;
            end
          end
        end
        default: ;  // unknown kind leaves the table alone
      endcase
      r.found_count = FOUND_W'(found);
      r.entry_count = ENTRY_W'(count);
      r.is_full     = (count >= lim);
      r.is_empty    = (count == 0);
      awaited_replies.push_back(r);
    endfunction

    task report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] exp_v);
      $display("%0t mismatch %s: got %h, expected %h", $time, what, got, exp_v);
      errors++;
    endtask

    task compare_field(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] exp_v);
      if (got !== exp_v) report(what, got, exp_v);
    endtask

    task check_reply(logic [OUT_TDATA_W-1:0] data);
      res_t got;
      res_t want;
      got = data[$bits(res_t)-1:0];
      if (awaited_replies.size() == 0) begin
        report("reply with no request outstanding", data[DATA_W-1:0], '0);
      end else begin
        want = awaited_replies.pop_front();
        compare_field("status", DATA_W'(got.status), DATA_W'(want.status));
        compare_field("first_value", got.first_value, want.first_value);
        compare_field("second_value", got.second_value, want.second_value);
        compare_field("found_count", DATA_W'(got.found_count), DATA_W'(want.found_count));
        compare_field("entry_count", DATA_W'(got.entry_count), DATA_W'(want.entry_count));
        compare_field("is_full", DATA_W'(got.is_full), DATA_W'(want.is_full));
        compare_field("is_empty", DATA_W'(got.is_empty), DATA_W'(want.is_empty));
        compare_field("padding", DATA_W'(data[OUT_TDATA_W-1:$bits(res_t)]), '0);
      end
    endtask
  endclass

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [DATA_W-1:0]      cfg_data  = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;  // key[31:0], value[63:32]
  logic [KIND_W-1:0]      in_tuser  = '0;  // kind[1:0]
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // status[1:0], first_value[33:2], second_value[65:34], found_count[67:66],
  // entry_count[72:68], is_full[73], is_empty[74], zero[79:75]
  logic [OUT_TDATA_W-1:0] out_tdata;

  multimap_checker board = new();
  bit steady = 0;  // no idling on either side while set

  two_value_multimap_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Offer one request and hold it until the transfer
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] key,
                              input logic [DATA_W-1:0] val);
    int gap;
    in_tuser  <= kind;
    in_tdata  <= {val, key};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_request(kind, key, val);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Write both registers once the table has answered everything
  task automatic set_config(input logic [CAP_W-1:0] cap, input logic [DATA_W-1:0] absent_v);
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CAP;
    cfg_data  <= DATA_W'(cap);
    @(posedge clk);
    cfg_index <= CFG_ABSENT;
    cfg_data  <= absent_v;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_register(CFG_CAP, DATA_W'(cap));
    board.set_register(CFG_ABSENT, absent_v);
  endtask

  // Reply side: random ready, one long hold-off to back up the input
  int hold = 0;
  int long_hold = 0;
  int replies_seen = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        board.check_reply(out_tdata);
        replies_seen++;
        if (replies_seen == STALL_AT) long_hold = STALL_CYCLES;
      end
      if (long_hold > 0) begin
        long_hold--;
        out_tready <= 1'b0;
      end else if (steady) begin
        out_tready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  // Watchdog on cycles with no transfer
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [CAP_W-1:0]  caps [RAND_PHASES];
    logic [DATA_W-1:0] key_pool [6];
    logic [DATA_W-1:0] val_pool [4];
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] val;
    logic [DATA_W-1:0] absent_v;
    int                r;
    int                idx;

    caps = '{5'd16, 5'd1, 5'd3, 5'd31, 5'd0, 5'd9, 5'd16, 5'd20};

    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: duplicates, per-key limit, search order, swap on remove
    send_request(KIND_ADD, 32'h8000_0000, 32'h7fff_ffff);
    send_request(KIND_ADD, 32'h8000_0000, 32'h8000_0000);
    send_request(KIND_ADD, 32'h8000_0000, 32'h0000_0000);   // third value for key refused
    send_request(KIND_ADD, 32'h7fff_ffff, 32'hffff_ffff);
    send_request(KIND_SEARCH, 32'h8000_0000, 32'h0000_0000);
    send_request(KIND_SEARCH, 32'h7fff_ffff, 32'h0000_0000);
    send_request(KIND_SEARCH, 32'h0000_0000, 32'hffff_ffff); // missing key
    send_request(KIND_REMOVE, 32'h8000_0000, 32'h7fff_ffff); // last entry moves to slot 0
    send_request(KIND_SEARCH, 32'h8000_0000, 32'h0000_0000);
    send_request(KIND_REMOVE, 32'h7fff_ffff, 32'h0000_0000); // value mismatch
    send_request(KIND_UNUSED, 32'h1234_5678, 32'hffff_ffff); // unknown kind
    send_request(KIND_REMOVE, 32'h8000_0000, 32'h8000_0000);
    send_request(KIND_REMOVE, 32'h7fff_ffff, 32'hffff_ffff);
    send_request(KIND_REMOVE, 32'h7fff_ffff, 32'hffff_ffff); // remove from empty table

    // Small capacity: fill up and get refused as full
    set_config(5'd2, 32'h8000_0000);
    send_request(KIND_ADD, 32'd1, 32'd1);
    send_request(KIND_ADD, 32'd2, 32'd2);
    send_request(KIND_ADD, 32'd3, 32'd3);
    send_request(KIND_SEARCH, 32'd3, 32'd0);

    // Zero capacity acts as one, now below the stored count
    set_config(5'd0, 32'h7fff_ffff);
    send_request(KIND_ADD, 32'd5, 32'd5);
    send_request(KIND_SEARCH, 32'd1, 32'd0);
    send_request(KIND_REMOVE, 32'd1, 32'd1);

    // Oversized capacity saturates to the table depth
    set_config(5'd31, 32'hffff_ffff);
    send_request(KIND_ADD, 32'd6, 32'd6);
    send_request(KIND_ADD, 32'd6, 32'd7);
    send_request(KIND_ADD, 32'd6, 32'd8);

    // Random phases over several settings
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase % 4)
        0: absent_v = $urandom;
        1: absent_v = 32'h8000_0000;
        2: absent_v = 32'h7fff_ffff;
        default: absent_v = 32'hffff_ffff;
      endcase
      set_config(caps[phase], absent_v);
      steady = (phase % 3 == 1);
      foreach (key_pool[i]) key_pool[i] = $urandom;
      foreach (val_pool[i]) val_pool[i] = $urandom;
      key_pool[5] = (phase % 2) ? 32'h8000_0000 : 32'h7fff_ffff;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 40) kind = KIND_ADD;
        else if (r < 70) kind = KIND_SEARCH;
        else if (r < 95) kind = KIND_REMOVE;
        else kind = KIND_UNUSED;
        key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 5)] : $urandom;
        val = ($urandom_range(0, 3) == 0) ? $urandom : val_pool[$urandom_range(0, 3)];
        // most removes target a stored pair
        if (kind == KIND_REMOVE && board.count > 0 && $urandom_range(0, 3) != 0) begin
          idx = $urandom_range(0, board.count - 1);
          key = board.keys[idx];
          val = board.vals[idx];
        end
        send_request(kind, key, val);
      end
    end

    // Drain
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/mvt_pkg.sv
sv/mvt_ram.sv
sv/mvt_ctrl.sv
sv/two_value_multimap_table.sv
verif/two_value_multimap_table_tb.sv
